// File: src/c3rb_pkg.sv
// Shared types, constants and column-word helpers for the 3x3 reflect-border convolution.
// Depends on nothing; every other file of the block but c3rb_ram imports it.
`timescale 1ns / 1ps

package c3rb_pkg;

	localparam int MAX_SIZE   = 32;
	localparam int SIZE_W     = 6;
	localparam int COL_W      = $clog2(MAX_SIZE);
	localparam int SAMPLE_W   = 16;
	localparam int VALUE_W    = 19;
	localparam int SLOTS      = 3;
	localparam int WORD_W     = SLOTS * SAMPLE_W;
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);
	localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
	localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_SIZE);

	// Row slot inside a column word: row r lives in slot r mod 3
	typedef logic [1:0] slot_t;

	typedef enum logic [1:0] {
		OP_MERGE,
		OP_READ,
		OP_DUP
	} op_kind_t;

	typedef struct packed {
		logic              valid;
		logic [COL_W-1:0]  y;
		logic [COL_W-1:0]  x;
		logic              last;
		logic              x_zero;
		slot_t             up;
		slot_t             mid;
		slot_t             down;
	} job_t;

	typedef struct packed {
		op_kind_t            kind;
		logic [COL_W-1:0]    addr;
		slot_t               wslot;
		logic [SAMPLE_W-1:0] sample;
		job_t                job;
	} op_t;

	function automatic slot_t slot_next(input slot_t s);
		slot_t n;
		case (s)
			2'd0:    n = 2'd1;
			2'd1:    n = 2'd2;
			default: n = 2'd0;
		endcase
		return n;
	endfunction

	function automatic slot_t slot_prev(input slot_t s);
		slot_t n;
		case (s)
			2'd0:    n = 2'd2;
			2'd1:    n = 2'd0;
			default: n = 2'd1;
		endcase
		return n;
	endfunction

	function automatic logic [SAMPLE_W-1:0] word_get(input logic [WORD_W-1:0] w, input slot_t s);
		logic [SAMPLE_W-1:0] v;
		case (s)
			2'd0:    v = w[0 +: SAMPLE_W];
			2'd1:    v = w[SAMPLE_W +: SAMPLE_W];
			2'd2:    v = w[2*SAMPLE_W +: SAMPLE_W];
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [WORD_W-1:0] word_put(input logic [WORD_W-1:0] w, input slot_t s,
			input logic [SAMPLE_W-1:0] v);
		logic [WORD_W-1:0] r;
		r = w;
		case (s)
			2'd0:    r[0 +: SAMPLE_W] = v;
			2'd1:    r[SAMPLE_W +: SAMPLE_W] = v;
			2'd2:    r[2*SAMPLE_W +: SAMPLE_W] = v;
			default: r = w;
		endcase
		return r;
	endfunction

endpackage

// File: src/conv3x3_reflect_border_top.sv
// Top level of the 3x3 convolution with mirrored borders: issue sequencer, line RAM, window.
// Depends on c3rb_pkg, c3rb_issue, c3rb_ram and c3rb_window.
`timescale 1ns / 1ps

//  channel   handshake                   payload                             dir
//  -------   -------------------------   ---------------------------------   ---
//  sample    sample_valid / sample_stall sample (s16, Q11.5)                 in
//  result    result_valid / result_stall value (s19), out_row, out_col,      out
//                                        frame_last
//  config    matrix_size_we              matrix_size_wdata (6 bits)          in
//
//  One request per cycle is taken while a row is under way and no result is held;
//  the line RAM is read and written once per sample, so within a row the rate is
//  one sample per cycle. The sample that closes a row (other than row 0) is followed
//  by a row-end repeat for its second result. The last sample of the matrix is followed
//  by the row-end repeat, a flush that walks the RAM read port over all N columns,
//  and the closing corner repeat. Results pass the op_s1, job_s2 and output registers.
//  Reset clears the counters and the size (8); the line RAM is not cleared.
//  result_stall holds the whole pipeline while a result is waiting, and sample_stall rises with it.

module conv3x3_reflect_border_top import c3rb_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      matrix_size_we,
	input  logic [SIZE_W-1:0]         matrix_size_wdata,
	input  logic                      sample_valid,
	output logic                      sample_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic signed [VALUE_W-1:0] value,
	output logic [COL_W-1:0]          out_row,
	output logic [COL_W-1:0]          out_col,
	output logic                      frame_last
);

	// Advance strobe: the whole pipeline moves together, held by the result side
	logic              adv;
	logic              op_valid;
	op_t               op;
	logic              ram_we;
	logic [COL_W-1:0]  ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;

	// Position tracking, size clamp, row-end repeat and final-row flush
	c3rb_issue u_issue (
		.clk               (clk),
		.arst_n            (arst_n),
		.matrix_size_we    (matrix_size_we),
		.matrix_size_wdata (matrix_size_wdata),
		.sample_valid      (sample_valid),
		.sample            (sample),
		.sample_stall      (sample_stall),
		.adv               (adv),
		.op_valid          (op_valid),
		.op                (op)
	);

	// One word per column holds three rows, row r in slot r mod 3
	c3rb_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_SIZE)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (adv),
		.raddr (op.addr),
		.rdata (ram_rdata)
	);

	// Merge the sample, write back, shift the window and form the sum
	c3rb_window u_win (
		.clk          (clk),
		.arst_n       (arst_n),
		.op_valid     (op_valid),
		.op           (op),
		.adv          (adv),
		.ram_rdata    (ram_rdata),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.value        (value),
		.out_row      (out_row),
		.out_col      (out_col),
		.frame_last   (frame_last)
	);

endmodule

// File: src/c3rb_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module c3rb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/c3rb_issue.sv
// Front sequencer: tracks the raster position, clamps the size and issues one op per cycle unless held by adv.
// Depends on c3rb_pkg.
`timescale 1ns / 1ps

module c3rb_issue import c3rb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                matrix_size_we,
	input  logic [SIZE_W-1:0]   matrix_size_wdata,
	input  logic                sample_valid,
	input  logic [SAMPLE_W-1:0] sample,
	output logic                sample_stall,
	input  logic                adv,
	output logic                op_valid,
	output op_t                 op
);

	typedef enum logic [1:0] {
		SEQ_IN,
		SEQ_EXTRA,
		SEQ_FLUSH,
		SEQ_END
	} seq_t;

	seq_t              seq_q;
	logic [SIZE_W-1:0] size_q;
	logic [COL_W-1:0]  row_q, col_q;
	slot_t             rm_q;
	logic [COL_W-1:0]  ex_row_q, ex_nm1_q, fcol_q;
	slot_t             ex_rm_q;
	logic              ex_last_q;

	logic [SIZE_W-1:0] n_cl, nm1_full;
	logic [COL_W-1:0]  nm1, r, c;
	slot_t             rm;
	logic              restart, row_end, frame_end, accept;

	always_comb begin
		if (size_q < SIZE_MIN) begin
			n_cl = SIZE_MIN;
		end else if (size_q > SIZE_MAX) begin
			n_cl = SIZE_MAX;
		end else begin
			n_cl = size_q;
		end
		nm1_full  = n_cl - SIZE_W'(1);
		nm1       = nm1_full[COL_W-1:0];
		restart   = (SIZE_W'(row_q) >= n_cl) || (SIZE_W'(col_q) >= n_cl);
		r         = restart ? '0 : row_q;
		c         = restart ? '0 : col_q;
		rm        = restart ? 2'd0 : rm_q;
		row_end   = (c == nm1);
		frame_end = row_end && (r == nm1);
	end

	assign sample_stall = !(adv && seq_q == SEQ_IN);
	assign accept       = sample_valid && !sample_stall;

	always_comb begin
		op       = '0;
		op_valid = 1'b0;
		case (seq_q)
			SEQ_IN: begin
				op_valid        = sample_valid;
				op.kind         = OP_MERGE;
				op.addr         = c;
				op.wslot        = rm;
				op.sample       = sample;
				op.job.valid    = (r != '0) && (c != '0);
				op.job.y        = r - COL_W'(1);
				op.job.x        = c - COL_W'(1);
				op.job.x_zero   = (c == COL_W'(1));
				op.job.down     = rm;
				op.job.mid      = slot_prev(rm);
				op.job.up       = (r == COL_W'(1)) ? slot_prev(rm) : slot_next(rm);
			end
			SEQ_EXTRA: begin
				op_valid        = 1'b1;
				op.kind         = OP_DUP;
				op.job.valid    = 1'b1;
				op.job.y        = ex_row_q - COL_W'(1);
				op.job.x        = ex_nm1_q;
				op.job.x_zero   = (ex_nm1_q == '0);
				op.job.down     = ex_rm_q;
				op.job.mid      = slot_prev(ex_rm_q);
				op.job.up       = (ex_row_q == COL_W'(1)) ? slot_prev(ex_rm_q) : slot_next(ex_rm_q);
			end
			SEQ_FLUSH: begin
				op_valid        = 1'b1;
				op.kind         = OP_READ;
				op.addr         = fcol_q;
				op.job.valid    = (fcol_q != '0);
				op.job.y        = ex_nm1_q;
				op.job.x        = fcol_q - COL_W'(1);
				op.job.x_zero   = (fcol_q == COL_W'(1));
				op.job.down     = ex_rm_q;
				op.job.mid      = ex_rm_q;
				op.job.up       = slot_prev(ex_rm_q);
			end
			SEQ_END: begin
				op_valid        = 1'b1;
				op.kind         = OP_DUP;
				op.job.valid    = 1'b1;
				op.job.y        = ex_nm1_q;
				op.job.x        = ex_nm1_q;
				op.job.last     = 1'b1;
				op.job.x_zero   = (ex_nm1_q == '0);
				op.job.down     = ex_rm_q;
				op.job.mid      = ex_rm_q;
				op.job.up       = slot_prev(ex_rm_q);
			end
			default: begin
				op_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q     <= SEQ_IN;
			size_q    <= SIZE_RESET;
			row_q     <= '0;
			col_q     <= '0;
			rm_q      <= 2'd0;
			ex_row_q  <= '0;
			ex_nm1_q  <= '0;
			ex_rm_q   <= 2'd0;
			ex_last_q <= 1'b0;
			fcol_q    <= '0;
		end else begin
			if (matrix_size_we) begin
				size_q <= matrix_size_wdata;
			end
			if (adv) begin
				case (seq_q)
					SEQ_IN: begin
						if (sample_valid) begin
							if (row_end) begin
								col_q <= '0;
								row_q <= frame_end ? '0 : r + COL_W'(1);
								rm_q  <= frame_end ? 2'd0 : slot_next(rm);
							end else begin
								row_q <= r;
								col_q <= c + COL_W'(1);
								rm_q  <= rm;
							end
							if (row_end && r != '0) begin
								seq_q     <= SEQ_EXTRA;
								ex_row_q  <= r;
								ex_rm_q   <= rm;
								ex_nm1_q  <= nm1;
								ex_last_q <= frame_end;
							end
						end
					end
					SEQ_EXTRA: begin
						fcol_q <= '0;
						seq_q  <= ex_last_q ? SEQ_FLUSH : SEQ_IN;
					end
					SEQ_FLUSH: begin
						if (fcol_q == ex_nm1_q) begin
							seq_q <= SEQ_END;
						end else begin
							fcol_q <= fcol_q + COL_W'(1);
						end
					end
					SEQ_END: begin
						seq_q <= SEQ_IN;
					end
					default: begin
						seq_q <= SEQ_IN;
					end
				endcase
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_flush_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q == SEQ_FLUSH |-> fcol_q <= ex_nm1_q)
		else $error("flush column ran past the last column");

	a_extra_not_first_row: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q == SEQ_EXTRA |-> ex_row_q != '0)
		else $error("row-end result issued for the first row");

	a_frame_end_extra: assert property (@(posedge clk) disable iff (!arst_n)
		accept && frame_end |=> seq_q == SEQ_EXTRA && ex_last_q)
		else $error("last sample of the frame did not start the flush");
`endif

endmodule

// File: src/c3rb_window.sv
// Read-modify-write of column words, three-column window and the kernel sum with output register.
// Depends on c3rb_pkg; talks to the line RAM through its write port and read data.
`timescale 1ns / 1ps

module c3rb_window import c3rb_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      op_valid,
	input  op_t                       op,
	output logic                      adv,
	input  logic [WORD_W-1:0]         ram_rdata,
	output logic                      ram_we,
	output logic [COL_W-1:0]          ram_waddr,
	output logic [WORD_W-1:0]         ram_wdata,
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic signed [VALUE_W-1:0] value,
	output logic [COL_W-1:0]          out_row,
	output logic [COL_W-1:0]          out_col,
	output logic                      frame_last
);

	logic                      valid_s1;
	op_t                       op_s1;
	logic                      job_valid_s2;
	job_t                      job_s2;
	logic [WORD_W-1:0]         left_q, mid_q, right_q;
	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [COL_W-1:0]          row_q, col_q;
	logic                      last_q;

	logic [WORD_W-1:0]         merged, col_in, lcol;
	logic signed [VALUE_W-1:0] sum;

	assign adv = !out_valid_q || !result_stall;

	always_comb begin
		merged = (op_s1.kind == OP_MERGE) ? word_put(ram_rdata, op_s1.wslot, op_s1.sample)
		                                  : ram_rdata;
		col_in = (op_s1.kind == OP_DUP) ? right_q : merged;
	end

	assign ram_we    = adv && valid_s1 && op_s1.kind == OP_MERGE;
	assign ram_waddr = op_s1.addr;
	assign ram_wdata = merged;

	// Left column folds onto the middle one at the left border
	always_comb begin
		lcol = job_s2.x_zero ? mid_q : left_q;
		sum  = VALUE_W'(signed'(word_get(mid_q, job_s2.down)))
		     + VALUE_W'(signed'(word_get(lcol, job_s2.down)))
		     + VALUE_W'(signed'(word_get(lcol, job_s2.mid)))
		     - VALUE_W'(signed'(word_get(right_q, job_s2.mid)))
		     - VALUE_W'(signed'(word_get(right_q, job_s2.up)))
		     - VALUE_W'(signed'(word_get(mid_q, job_s2.up)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			job_valid_s2 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else if (adv) begin
			valid_s1     <= op_valid;
			job_valid_s2 <= valid_s1 && op_s1.job.valid;
			out_valid_q  <= job_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1  <= op;
			job_s2 <= op_s1.job;
			if (valid_s1) begin
				left_q  <= mid_q;
				mid_q   <= right_q;
				right_q <= col_in;
			end
			value_q <= sum;
			row_q   <= job_s2.y;
			col_q   <= job_s2.x;
			last_q  <= job_s2.last;
		end
	end

	assign result_valid = out_valid_q;
	assign value        = value_q;
	assign out_row      = row_q;
	assign out_col      = col_q;
	assign frame_last   = last_q;

`ifndef NO_ASSERTIONS
	a_last_on_corner: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_last |-> out_row == out_col)
		else $error("frame end flagged off the lower-right corner");

	a_dup_repeats_right: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s1 && op_s1.kind == OP_DUP |=> right_q == mid_q)
		else $error("border repeat did not duplicate the right column");

	a_dup_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s1 && op_s1.kind == OP_DUP |=> job_valid_s2)
		else $error("border repeat carried no result");
`endif

endmodule
